// ===== hw/rtl/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// shared constants and codes of the sorted insert statistics block
// ----------------------------------------------------------------------------
package sis_pkg;

	localparam int MAX_ITEMS_DEF = 256;

	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int MEAN_W   = 39;
	localparam int TOTAL_W  = 9;
	localparam int STATUS_W = 2;
	localparam int OUT_BITS = MEDIAN_W + MEAN_W + SAMPLE_W + 1 + TOTAL_W + STATUS_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_END    = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_DROPPED = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/sorted_insert_statistics.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_statistics
// sorted store of signed samples with median, mean and repeat summary
// ----------------------------------------------------------------------------
// input channel: s_tdata carries a sample, s_tuser the kind (0 insert, 1 end).
// an insert word places the sample in ascending order in an internal memory;
// it reads each entry from the top down and shifts it up one place while it
// is greater than the sample, then writes the sample into the freed place,
// in a read-compare-write loop over one read port and one write port.
// a sample arriving with the store full is dropped and flagged.
// an end word walks the store, then runs a bit-serial divider for the mean
// (one quotient bit a cycle), then emits one summary word on m_tdata and
// clears the set.
// an empty set emits at once with status empty.
// one word is handled at a time; s_tready is high only while idle.
// the summary sits in an output register, so inserts go on while the
// receiver stalls; a second summary waits until the first is taken.
// reset empties the set and drops any pending summary; memory contents
// are not cleared, only entries below the held count are ever used.
// ----------------------------------------------------------------------------
module sorted_insert_statistics
	import sis_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// sample[31:0]
	input  logic [SAMPLE_W-1:0] s_tdata,
	// kind[0]
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// median_doubled[32:0], mean_hundredths[71:33], repeat_value[103:72],
	// repeat_found[104], item_total[113:105], status[115:114], zero pad
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int AW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int NUM_W  = SUM_W + 8;
	localparam int RW     = CNT_W + 1;
	localparam int DCNT_W = $clog2(NUM_W + 1);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_INS_RD  = 6'b000010,
		ST_INS_CMP = 6'b000100,
		ST_WALK    = 6'b001000,
		ST_DIV     = 6'b010000,
		ST_EMIT    = 6'b100000
	} state_t;

	state_t state_q;

	logic [SAMPLE_W-1:0] mem [MAX_ITEMS];
	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [SAMPLE_W-1:0] mem_wd;
	logic [AW-1:0]       mem_ra;
	logic [SAMPLE_W-1:0] rd_data_s1;

	logic [CNT_W-1:0]       count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                   dropped_q;

	logic [CNT_W-1:0]       pos_q;
	logic signed [SAMPLE_W-1:0] val_q;

	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   rd_valid_s1;
	logic [CNT_W-1:0]       rd_idx_s1;
	logic [SAMPLE_W-1:0]    prev_q;
	logic [SAMPLE_W-1:0]    lo_q;
	logic [SAMPLE_W-1:0]    hi_q;
	logic [SAMPLE_W-1:0]    rep_q;
	logic                   found_q;
	logic                   neg_q;
	logic                   empty_q;
	logic                   drop_snap_q;

	logic [NUM_W-1:0]       num_q;
	logic [RW-1:0]          rem_q;
	logic [DCNT_W-1:0]      div_cnt_q;

	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;

	logic                   s_acc;
	logic [CNT_W-1:0]       half;
	logic [SUM_W-1:0]       mag;
	logic [NUM_W-1:0]       num_init;
	logic [RW:0]            rem_sh;
	logic [RW:0]            div_d;
	logic                   emit_ok;
	logic signed [MEDIAN_W-1:0] median;
	logic [NUM_W-1:0]       mean_full;
	status_t                status;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign half     = n_q >> 1;
	assign mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	// mag*200 + n, the numerator of the rounded mean
	assign num_init = (NUM_W'(mag) << 7) + (NUM_W'(mag) << 6) + (NUM_W'(mag) << 3)
		+ NUM_W'(count_q);
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign div_d    = {1'b0, n_q, 1'b0};
	assign emit_ok  = !m_valid_q || m_tready;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q[AW-1:0];
		mem_wd = val_q;
		mem_ra = rd_idx_q[AW-1:0];
		unique case (state_q)
			ST_INS_RD: begin
				mem_ra = AW'(pos_q - CNT_W'(1));
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if ($signed(rd_data_s1) > val_q) begin
					mem_wd = rd_data_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[mem_ra];
	end

	always_comb begin
		if (n_q[0]) begin
			median = MEDIAN_W'($signed(hi_q)) <<< 1;
		end else begin
			median = MEDIAN_W'($signed(lo_q)) + MEDIAN_W'($signed(hi_q));
		end
		mean_full = neg_q ? NUM_W'(-num_q) : num_q;
		if (empty_q) begin
			status = STATUS_EMPTY;
		end else if (drop_snap_q) begin
			status = STATUS_DROPPED;
		end else begin
			status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			dropped_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			// a new summary may replace one taken in the same cycle
			if (state_q == ST_EMIT && emit_ok) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == KIND_INSERT) begin
							if (count_q == CNT_W'(MAX_ITEMS)) begin
								dropped_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
								sum_q   <= sum_q + SUM_W'($signed(s_tdata));
								state_q <= ST_INS_RD;
							end
						end else if (count_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_INS_RD: begin
					if (pos_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if ($signed(rd_data_s1) > val_q) begin
						state_q <= ST_INS_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					rd_valid_s1 <= (rd_idx_q < n_q);
					if (rd_valid_s1 && rd_idx_s1 == n_q - CNT_W'(1)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DCNT_W'(NUM_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						count_q   <= '0;
						sum_q     <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				pos_q       <= count_q;
				val_q       <= $signed(s_tdata);
				n_q         <= count_q;
				rd_idx_q    <= '0;
				rep_q       <= '0;
				found_q     <= 1'b0;
				lo_q        <= '0;
				hi_q        <= '0;
				neg_q       <= sum_q[SUM_W-1];
				empty_q     <= (count_q == '0);
				drop_snap_q <= dropped_q;
				num_q       <= num_init;
				rem_q       <= '0;
				div_cnt_q   <= '0;
			end
			ST_INS_CMP: begin
				if ($signed(rd_data_s1) > val_q) begin
					pos_q <= pos_q - CNT_W'(1);
				end
			end
			ST_WALK: begin
				if (rd_idx_q < n_q) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (rd_valid_s1) begin
					prev_q <= rd_data_s1;
					if (rd_idx_s1 != '0 && rd_data_s1 == prev_q) begin
						rep_q   <= rd_data_s1;
						found_q <= 1'b1;
					end
					if (rd_idx_s1 == half - CNT_W'(1)) begin
						lo_q <= rd_data_s1;
					end
					if (rd_idx_s1 == half) begin
						hi_q <= rd_data_s1;
					end
				end
			end
			ST_DIV: begin
				// restoring division, quotient bits shift into num_q
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
				if (rem_sh >= div_d) begin
					rem_q <= RW'(rem_sh - div_d);
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[RW-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			ST_EMIT: begin
				if (emit_ok) begin
					if (empty_q) begin
						m_data_q <= {
							{(OUT_W - OUT_BITS){1'b0}}, status,
							{(OUT_BITS - STATUS_W){1'b0}}};
					end else begin
						m_data_q <= {
							{(OUT_W - OUT_BITS){1'b0}}, status, TOTAL_W'(n_q),
							found_q, rep_q, mean_full[MEAN_W-1:0], median};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("held count beyond capacity");

	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_INS_RD || state_q == ST_INS_CMP))
		else $error("store written outside insert");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == KIND_INSERT && count_q != CNT_W'(MAX_ITEMS))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance count");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_ok) |=> (m_tvalid && count_q == '0))
		else $error("summary not emitted or set not cleared");

endmodule

// ===== bench/tb_sorted_insert_statistics.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_insert_statistics
// stream-level check of the sorted insert statistics block: a queue-fed driver
// and a monitor compare every summary word against a behavioral predictor
// ----------------------------------------------------------------------------
module tb_sorted_insert_statistics;
	import sis_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = MAX_ITEMS_DEF;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] sample;
		logic                hold;	// wait until all summaries arrived before sending
	} in_word_t;

	// lowest field last, to match the word layout
	typedef struct packed {
		status_t             status;
		logic [TOTAL_W-1:0]  item_total;
		logic                repeat_found;
		logic [SAMPLE_W-1:0] repeat_value;
		logic [MEAN_W-1:0]   mean_hundredths;
		logic [MEDIAN_W-1:0] median_doubled;
	} summary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	sorted_insert_statistics dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	in_word_t pending_words[$];
	summary_t expected_summaries[$];
	logic signed [31:0] held_values[$];
	logic signed [39:0] sum_acc = '0;
	bit dropped_seen = 1'b0;
	bit stimulus_done = 1'b0;
	int mismatch_count = 0;
	int summaries_seen = 0;
	int inserts_sent = 0;
	int drops_sent = 0;
	int idle_cycles = 0;

	// predictor: keeps the held set sorted and builds the summary on an end word
	function automatic void predict_word(in_word_t w);
		summary_t s;
		int n;
		int pos;
		logic [63:0] mag;
		logic [63:0] q;
		logic signed [63:0] m2;
		s = '0;
		if (w.kind == KIND_INSERT) begin
			if (held_values.size() >= DEPTH) begin
				dropped_seen = 1'b1;
			end else begin
				// equal samples go after the ones already held
				pos = held_values.size();
				while (pos > 0 && held_values[pos-1] > $signed(w.sample))
					pos--;
				held_values.insert(pos, $signed(w.sample));
				sum_acc += $signed(w.sample);
			end
			return;
		end
		n = held_values.size();
		if (n == 0) begin
			s.status = STATUS_EMPTY;
		end else begin
			if (n % 2)
				m2 = 2 * 64'(held_values[n/2]);
			else
				m2 = 64'(held_values[n/2-1]) + 64'(held_values[n/2]);
			s.median_doubled = m2[MEDIAN_W-1:0];
			mag = sum_acc < 0 ? -64'(sum_acc) : 64'(sum_acc);
			mag = mag * 100;
			q = (2 * mag + n) / (2 * n);
			if (sum_acc < 0)
				q = -q;
			s.mean_hundredths = q[MEAN_W-1:0];
			for (int i = 0; i + 1 < n; i++) begin
				if (held_values[i] == held_values[i+1]) begin
					s.repeat_value = held_values[i];
					s.repeat_found = 1'b1;
				end
			end
			s.item_total = TOTAL_W'(n);
			s.status = dropped_seen ? STATUS_DROPPED : STATUS_OK;
		end
		expected_summaries.push_back(s);
		held_values.delete();
		sum_acc = '0;
		dropped_seen = 1'b0;
	endfunction

	function automatic void add_word(logic kind, logic [31:0] sample, logic hold = 1'b0);
		in_word_t w;
		w.kind = kind;
		w.sample = sample;
		w.hold = hold;
		pending_words.push_back(w);
	endfunction

	function automatic logic [31:0] random_sample(int pool);
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, pool) - pool / 2;
			default: return $urandom();
		endcase
	endfunction

	function automatic int inserts_total();
		int c;
		c = 0;
		foreach (pending_words[i])
			if (pending_words[i].kind == KIND_INSERT)
				c++;
		return c;
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				s_tvalid <= 1'b0;
				send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
				if (!s_tuser)
					inserts_sent++;
			end else if (!s_tvalid && send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (!s_tvalid && pending_words.size() > 0) begin
				if (!pending_words[0].hold || expected_summaries.size() == 0) begin
					in_word_t w;
					w = pending_words.pop_front();
					predict_word(w);
					s_tvalid <= 1'b1;
					s_tuser <= w.kind;
					s_tdata <= w.sample;
				end
			end
		end
	end

	// monitor
	int recv_gap = 0;
	int wait_draw;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				summary_t got;
				summary_t exp;
				got = m_tdata[$bits(summary_t)-1:0];
				summaries_seen++;
				if (expected_summaries.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected summary word %h", got);
				end else begin
					exp = expected_summaries.pop_front();
					if (got !== exp) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("summary mismatch: expected med2=%0d mean=%0d rep=%0d/%0b n=%0d st=%0d, got med2=%0d mean=%0d rep=%0d/%0b n=%0d st=%0d",
								$signed(exp.median_doubled), $signed(exp.mean_hundredths),
								$signed(exp.repeat_value), exp.repeat_found, exp.item_total,
								exp.status, $signed(got.median_doubled),
								$signed(got.mean_hundredths), $signed(got.repeat_value),
								got.repeat_found, got.item_total, got.status);
					end
				end
				// receiver draws a random wait before taking the next word
				wait_draw = $urandom_range(0, 9);
				recv_gap <= wait_draw;
				m_tready <= (wait_draw == 0);
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= (recv_gap == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int set_size;
		int pool;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty set, extremes, rounding, minus one repeat
		add_word(KIND_END, '0);
		add_word(KIND_INSERT, 32'h7fff_ffff);
		add_word(KIND_END, 32'hffff_ffff);
		add_word(KIND_INSERT, 32'h8000_0000);
		add_word(KIND_INSERT, 32'h8000_0000);
		add_word(KIND_INSERT, 32'h7fff_ffff);
		add_word(KIND_END, '0);
		add_word(KIND_INSERT, 32'hffff_ffff);
		add_word(KIND_INSERT, 32'hffff_ffff);
		add_word(KIND_INSERT, 32'd2);
		add_word(KIND_END, '0);
		add_word(KIND_INSERT, 32'd1);
		add_word(KIND_INSERT, 32'd2);
		add_word(KIND_INSERT, -32'sd3, 1'b1);
		add_word(KIND_END, '0);
		add_word(KIND_INSERT, -32'sd1);
		add_word(KIND_INSERT, 32'd0);
		add_word(KIND_INSERT, 32'd5);
		add_word(KIND_INSERT, 32'd5);
		add_word(KIND_INSERT, 32'd0);
		add_word(KIND_END, '0);

		// full store: fill with a mix of extremes, small and random samples, then overflow
		for (int i = 0; i < DEPTH + 3; i++)
			add_word(KIND_INSERT, random_sample(4));
		add_word(KIND_END, '0, 1'b1);

		// random sets, mostly small
		while (inserts_total() < 700) begin
			set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
			pool = ($urandom_range(0, 1)) ? 8 : 1000;
			for (int i = 0; i < set_size; i++)
				add_word(KIND_INSERT, random_sample(pool));
			add_word(KIND_END, $urandom(), $urandom_range(0, 19) == 0);
		end

		wait (pending_words.size() == 0 && !s_tvalid);
		wait (expected_summaries.size() == 0);
		repeat (800) @(posedge clk);
		$display("covered %0d inserts in %0d summaries, including an overflowed store",
			inserts_sent, summaries_seen);
		if (mismatch_count == 0 && expected_summaries.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sis_pkg.sv
hw/rtl/sorted_insert_statistics.sv
bench/tb_sorted_insert_statistics.sv
